### rtl/crsf_rc_frame_receiver_macros.svh
// Assertion macros for the CRSF RC frame receiver checker.
// Depends on signals named aclk and aresetn in the scope where a macro is used.
`ifndef CRSF_RC_FRAME_RECEIVER_MACROS_SVH
`define CRSF_RC_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CRSF_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CRSF_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

### rtl/crsf_pkg.sv
// Shared types, constants and state encodings for the CRSF RC frame receiver.
// No dependencies; every RTL module imports this package.
package crsf_pkg;

    // Frame store geometry.
    localparam int FRAME_DEPTH = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int COUNT_W     = $clog2(FRAME_DEPTH + 1);

    // Framing and CRC constants.
    localparam logic [7:0] CRC_POLY         = 8'hD5;
    localparam logic [7:0] TYPE_RC_CHANNELS = 8'h16;
    localparam logic [7:0] MIN_LENGTH       = 8'd2;
    localparam logic [7:0] MAX_LENGTH       = 8'(FRAME_DEPTH);

    // Channel unpacking.
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 11;
    localparam int CHAN_IDX_W   = 4;
    localparam int ACC_W        = CHAN_W + 7;
    localparam int BITS_W       = 5;
    localparam logic [ADDR_W-1:0]     FIRST_PAYLOAD_ADDR = ADDR_W'(1);
    localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL       = CHAN_IDX_W'(NUM_CHANNELS - 1);

    // Channel scaling: (raw - 172) * 1024 / 1639 + 988, clamped to 988..2012.
    localparam logic [CHAN_W-1:0] RAW_MIN  = 11'd172;
    localparam logic [CHAN_W-1:0] RAW_MAX  = 11'd1811;
    localparam logic [CHAN_W-1:0] OUT_MIN  = 11'd988;
    localparam logic [CHAN_W-1:0] OUT_MAX  = 11'd2012;
    localparam longint unsigned   RAW_SPAN = longint'(RAW_MAX) - longint'(RAW_MIN);
    localparam int OUT_SPAN_LOG2 = 10;
    localparam int RECIP_SHIFT   = 32;
    localparam int RECIP_W       = 22;
    localparam int PROD_SHIFT    = RECIP_SHIFT - OUT_SPAN_LOG2;
    localparam int PROD_W        = CHAN_W + RECIP_W;
    // Rounded-up reciprocal of the span; exact for every dividend below 2^21.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + RAW_SPAN - 64'd1) / RAW_SPAN;
    localparam logic [RECIP_W-1:0] MAP_RECIP = RECIP_W'(RECIP_FULL);

    // Link timeout.
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic {
        MODE_BYTE = 1'b0,
        MODE_TICK = 1'b1
    } in_mode_t;

    typedef enum logic {
        KIND_CHANNEL = 1'b0,
        KIND_STATUS  = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_LEN,
        PH_DATA
    } parse_phase_t;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_READ,
        DEC_LOAD,
        DEC_SCALE,
        DEC_MULT,
        DEC_EMIT
    } dec_state_t;

    // Frame store write and read requests.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

### rtl/crsf_frame_store.sv
// Frame byte store: one write port, one registered read port, per-entry written flags.
// Depends on crsf_pkg for geometry and request structs.
module crsf_frame_store import crsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  store_wr_t  wr,
    input  store_rd_t  rd,
    output logic [7:0] rd_data
);

    logic [7:0]             mem [FRAME_DEPTH];
    logic [FRAME_DEPTH-1:0] written_reg;
    logic [7:0]             rd_word_reg;
    logic                   rd_hit_reg;

    // Storage array with registered read data.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_word_reg <= mem[rd.addr];
        end
    end

    // Written flags make every entry read as zero until its first write after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_hit_reg <= written_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : 8'h00;

endmodule

### rtl/crsf_chan_map.sv
// Two-stage channel scaling unit: raw 11-bit value to a 988..2012 pulse width.
// Depends on crsf_pkg for the scaling constants.
module crsf_chan_map import crsf_pkg::*; (
    input  logic              aclk,
    input  logic              start,
    input  logic [CHAN_W-1:0] raw,
    output logic [CHAN_W-1:0] value
);

    logic [CHAN_W-1:0] diff_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CHAN_W-1:0] quot;
    logic [CHAN_W:0]   sum;

    // Stage one takes the offset from the low end; values at or below it map to zero.
    // Stage two multiplies by the reciprocal of the span.
    always_ff @(posedge aclk) begin
        if (start) begin
            diff_reg <= (raw > RAW_MIN) ? (raw - RAW_MIN) : '0;
        end
        prod_reg <= PROD_W'(diff_reg) * PROD_W'(MAP_RECIP);
    end

    // Quotient, offset and clamp to the top of the range.
    always_comb begin
        quot  = prod_reg[PROD_SHIFT +: CHAN_W];
        sum   = {1'b0, quot} + {1'b0, OUT_MIN};
        value = (sum > {1'b0, OUT_MAX}) ? OUT_MAX : sum[CHAN_W-1:0];
    end

endmodule

### rtl/crsf_rc_frame_receiver.sv
// CRSF RC frame receiver: each accepted request is either a received byte or a
// millisecond tick. The last byte of a valid RC channels frame starts a decode that
// reads stored bytes 1 to 22 from the frame store, each in a read state and then a
// load state, and passes each channel through the two-stage scaling unit until all
// sixteen results are out, during which no request is taken. The read port of the
// frame store and the scaling unit are used by one channel at a time. Every tick
// is taken only when the output register is free, since it may raise a status
// result; bytes are taken whenever no decode runs. The frame store reads as zero
// after reset through per-entry written flags, so there is no clearing pass.
// Depends on crsf_pkg, crsf_frame_store and crsf_chan_map.
module crsf_rc_frame_receiver import crsf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    // Input requests.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [7:0]            s_rx_byte,
    // Result requests.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [CHAN_IDX_W-1:0] m_channel_index,
    output logic [CHAN_W-1:0]     m_channel_value,
    output logic                  m_link_valid,
    output logic                  m_last
);

    // CRC-8, polynomial 0xD5, MSB first.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic [15:0]        timeout_reg;

    parse_phase_t       phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next, byte_count_inc;
    logic [7:0]         frame_len_reg, frame_len_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         type_reg, type_next;
    logic [15:0]        ticks_reg, ticks_next, ticks_inc;
    logic               link_ok_reg, link_ok_next;

    dec_state_t         dec_state_reg, dec_state_next;
    logic [ADDR_W-1:0]  rd_ptr_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic [CHAN_IDX_W-1:0] chan_reg;

    logic               m_valid_reg;
    result_kind_t       m_kind_reg;
    logic [CHAN_IDX_W-1:0] m_index_reg;
    logic [CHAN_W-1:0]  m_value_reg;
    logic               m_link_valid_reg;
    logic               m_last_reg;

    logic               s_accept, byte_accept, tick_accept;
    logic               out_free, frame_ok, link_lost;
    logic               dec_idle, map_start, chan_emit, bits_ready;
    store_wr_t          store_wr;
    store_rd_t          store_rd;
    logic [7:0]         store_rd_data;
    logic [CHAN_W-1:0]  map_value;

    // Request handshake; ticks need room in the output register for a status result.
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = dec_idle && ((s_mode == MODE_BYTE) || out_free);
    assign s_accept    = s_valid && s_ready;
    assign byte_accept = s_accept && (s_mode == MODE_BYTE);
    assign tick_accept = s_accept && (s_mode == MODE_TICK);

    // Timeout register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Frame parser: address, length, then data bytes written into the store.
    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        crc_next        = crc_reg;
        type_next       = type_reg;
        store_wr        = '0;
        frame_ok        = 1'b0;
        byte_count_inc  = byte_count_reg + 1'b1;
        if (byte_accept) begin
            unique case (phase_reg)
                PH_ADDR: begin
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    frame_len_next  = s_rx_byte;
                    byte_count_next = '0;
                    crc_next        = 8'h00;
                    if (s_rx_byte < MIN_LENGTH || s_rx_byte > MAX_LENGTH) begin
                        phase_next = PH_ADDR;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    store_wr.en     = 1'b1;
                    store_wr.addr   = byte_count_reg[ADDR_W-1:0];
                    store_wr.data   = s_rx_byte;
                    byte_count_next = byte_count_inc;
                    if (byte_count_reg == '0) begin
                        type_next = s_rx_byte;
                    end
                    if (8'(byte_count_inc) < frame_len_reg) begin
                        crc_next = crc_update(crc_reg, s_rx_byte);
                    end else begin
                        phase_next = PH_ADDR;
                        frame_ok   = (crc_reg == s_rx_byte) && (type_reg == TYPE_RC_CHANNELS);
                    end
                end
                default: begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
    end

    // Tick counter and link flag.
    always_comb begin
        ticks_inc    = (ticks_reg != TICK_MAX) ? (ticks_reg + 16'd1) : ticks_reg;
        link_lost    = tick_accept && link_ok_reg && (ticks_inc > timeout_reg);
        ticks_next   = ticks_reg;
        link_ok_next = link_ok_reg;
        if (frame_ok) begin
            ticks_next   = 16'd0;
            link_ok_next = 1'b1;
        end else if (tick_accept) begin
            ticks_next = ticks_inc;
            if (link_lost) begin
                link_ok_next = 1'b0;
            end
        end
    end

    // Parser and link state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_ADDR;
            byte_count_reg <= '0;
            frame_len_reg  <= 8'h00;
            crc_reg        <= 8'h00;
            ticks_reg      <= 16'd0;
            link_ok_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            frame_len_reg  <= frame_len_next;
            crc_reg        <= crc_next;
            ticks_reg      <= ticks_next;
            link_ok_reg    <= link_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
    end

    // Decoder next state: fetch bytes until a channel's bits are in, then scale and emit.
    assign bits_ready = (bits_reg >= BITS_W'(CHAN_W));

    always_comb begin
        dec_state_next = dec_state_reg;
        unique case (dec_state_reg)
            DEC_IDLE: begin
                if (frame_ok) begin
                    dec_state_next = DEC_READ;
                end
            end
            DEC_READ: begin
                dec_state_next = bits_ready ? DEC_SCALE : DEC_LOAD;
            end
            DEC_LOAD: begin
                dec_state_next = DEC_READ;
            end
            DEC_SCALE: begin
                dec_state_next = DEC_MULT;
            end
            DEC_MULT: begin
                dec_state_next = DEC_EMIT;
            end
            DEC_EMIT: begin
                if (out_free) begin
                    dec_state_next = (chan_reg == LAST_CHANNEL) ? DEC_IDLE : DEC_READ;
                end
            end
            default: begin
                dec_state_next = DEC_IDLE;
            end
        endcase
    end

    // Decoder outputs.
    always_comb begin
        dec_idle      = (dec_state_reg == DEC_IDLE);
        store_rd.en   = (dec_state_reg == DEC_READ) && !bits_ready;
        store_rd.addr = rd_ptr_reg;
        map_start     = (dec_state_reg == DEC_SCALE);
        chan_emit     = (dec_state_reg == DEC_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_state_reg <= DEC_IDLE;
        end else begin
            dec_state_reg <= dec_state_next;
        end
    end

    // Decoder datapath: bit accumulator, read pointer and channel number.
    always_ff @(posedge aclk) begin
        if (dec_idle && frame_ok) begin
            rd_ptr_reg <= FIRST_PAYLOAD_ADDR;
            acc_reg    <= '0;
            bits_reg   <= '0;
            chan_reg   <= '0;
        end else begin
            if (dec_state_reg == DEC_LOAD) begin
                acc_reg    <= acc_reg | (ACC_W'(store_rd_data) << bits_reg);
                bits_reg   <= bits_reg + BITS_W'(8);
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (map_start) begin
                acc_reg  <= acc_reg >> CHAN_W;
                bits_reg <= bits_reg - BITS_W'(CHAN_W);
            end
            if (chan_emit) begin
                chan_reg <= chan_reg + 1'b1;
            end
        end
    end

    crsf_frame_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (store_rd_data)
    );

    crsf_chan_map u_map (
        .aclk  (aclk),
        .start (map_start),
        .raw   (acc_reg[CHAN_W-1:0]),
        .value (map_value)
    );

    // Output register: channel results from the decoder, status on link loss.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (chan_emit || link_lost) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (chan_emit) begin
            m_kind_reg       <= KIND_CHANNEL;
            m_index_reg      <= chan_reg;
            m_value_reg      <= map_value;
            m_link_valid_reg <= 1'b1;
            m_last_reg       <= (chan_reg == LAST_CHANNEL);
        end else if (link_lost) begin
            m_kind_reg       <= KIND_STATUS;
            m_index_reg      <= '0;
            m_value_reg      <= '0;
            m_link_valid_reg <= 1'b0;
            m_last_reg       <= 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_channel_index = m_index_reg;
    assign m_channel_value = m_value_reg;
    assign m_link_valid    = m_link_valid_reg;
    assign m_last          = m_last_reg;

endmodule

### rtl/crsf_checker.sv
// Port-level checker for the CRSF RC frame receiver, attached by bind.
// Depends on crsf_pkg and crsf_rc_frame_receiver_macros.svh.
`include "crsf_rc_frame_receiver_macros.svh"

module crsf_checker import crsf_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_kind,
    input logic [CHAN_IDX_W-1:0] m_channel_index,
    input logic [CHAN_W-1:0]     m_channel_value,
    input logic                  m_link_valid,
    input logic                  m_last
);

    logic stalled, status_seen, channel_seen, mid_burst;
    logic status_ok, range_ok, last_ok;

    // Conditions and expectations on the result port.
    assign stalled      = m_valid && !m_ready;
    assign status_seen  = m_valid && (m_kind == KIND_STATUS);
    assign channel_seen = m_valid && (m_kind == KIND_CHANNEL);
    assign mid_burst    = channel_seen && !m_last;
    assign status_ok    = (m_channel_index == '0) && (m_channel_value == '0)
                          && !m_link_valid && m_last;
    assign range_ok     = m_link_valid && (m_channel_value >= OUT_MIN)
                          && (m_channel_value <= OUT_MAX);
    assign last_ok      = (m_last == (m_channel_index == LAST_CHANNEL));

    // A stalled result keeps its value.
    `CRSF_ASSERT_NEXT(a_held, stalled, m_valid && $stable(m_channel_value), "held result changed")

    // A status result reports a lost link and carries no channel.
    `CRSF_ASSERT_IMPL(a_status_fields, status_seen, status_ok, "malformed status result")

    // Channel values stay in the pulse range with the link marked valid.
    `CRSF_ASSERT_IMPL(a_channel_range, channel_seen, range_ok, "channel value out of range")

    // The last channel closes the burst.
    `CRSF_ASSERT_IMPL(a_channel_last, channel_seen, last_ok, "last flag does not match channel")

    // No request is taken while a channel burst is still being produced.
    `CRSF_ASSERT_IMPL(a_burst_blocks_input, mid_burst, !s_ready, "input taken during burst")

endmodule

bind crsf_rc_frame_receiver crsf_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_kind          (m_kind),
    .m_channel_index (m_channel_index),
    .m_channel_value (m_channel_value),
    .m_link_valid    (m_link_valid),
    .m_last          (m_last)
);

### sim/tb.sv
// Self-checking testbench for crsf_rc_frame_receiver: frames, ticks and timeout settings
// go in, and every channel and link-lost result is checked against a predictor kept here.
// Depends on crsf_pkg and the receiver RTL.
module tb;
    import crsf_pkg::*;

    localparam int HOLD_CYCLES       = 400;
    localparam int SETTLE_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int LAST_PAYLOAD_BYTE = 22;
    localparam int CHANNEL_FRAME_LEN = LAST_PAYLOAD_BYTE + 2;
    localparam int OPENING_TICKS     = 12;
    localparam int MAX_TIMEOUT_TICKS = 20;

    typedef struct packed {
        result_kind_t            kind;
        logic [CHAN_IDX_W-1:0]   idx;
        logic [CHAN_W-1:0]       pulse;
        logic                    link;
        logic                    is_last;
    } rc_result_t;

    // One directed request; lost marks a row whose result is the link-lost status.
    typedef struct packed {
        in_mode_t   md;
        logic [7:0] b;
        logic       lost;
    } stim_row_t;

    localparam rc_result_t LINK_LOST_RESULT = '{KIND_STATUS, 4'd0, 11'd0, 1'b0, 1'b1};

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // The link is up from the opening frame, so the first tick past a timeout of 2
        // drops it.
        '{MODE_TICK, 8'hFF, 1'b1},
        // Lengths 0, 1, 65 and 255 each drop the frame.
        '{MODE_BYTE, 8'h00, 1'b0}, '{MODE_BYTE, 8'h00, 1'b0},
        '{MODE_BYTE, 8'hC8, 1'b0}, '{MODE_BYTE, 8'h01, 1'b0},
        '{MODE_BYTE, 8'hEE, 1'b0}, '{MODE_BYTE, 8'h41, 1'b0},
        '{MODE_BYTE, 8'hFF, 1'b0}, '{MODE_BYTE, 8'hFF, 1'b0},
        // Shortest channel frame with a good CRC: decodes older store contents.
        '{MODE_BYTE, 8'hC8, 1'b0}, '{MODE_BYTE, 8'h02, 1'b0},
        '{MODE_BYTE, TYPE_RC_CHANNELS, 1'b0}, '{MODE_BYTE, 8'hD3, 1'b0},
        // Same frame with a bad CRC byte.
        '{MODE_BYTE, 8'hC8, 1'b0}, '{MODE_BYTE, 8'h02, 1'b0},
        '{MODE_BYTE, TYPE_RC_CHANNELS, 1'b0}, '{MODE_BYTE, 8'h00, 1'b0},
        // Another frame type with a good CRC.
        '{MODE_BYTE, 8'hC8, 1'b0}, '{MODE_BYTE, 8'h02, 1'b0},
        '{MODE_BYTE, 8'h00, 1'b0}, '{MODE_BYTE, 8'h00, 1'b0},
        // Timeout of 2: the third tick drops the link, the fourth is silent.
        '{MODE_TICK, 8'h00, 1'b0}, '{MODE_TICK, 8'h5A, 1'b0},
        '{MODE_TICK, 8'hA5, 1'b1}, '{MODE_TICK, 8'hFF, 1'b0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [15:0]           cfg_wr_data = 16'd0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_mode = 1'b0;
    logic [7:0]            s_rx_byte = 8'd0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_kind;
    logic [CHAN_IDX_W-1:0] m_channel_index;
    logic [CHAN_W-1:0]     m_channel_value;
    logic                  m_link_valid;
    logic                  m_last;

    // Predictor state.
    parse_phase_t model_phase = PH_ADDR;
    logic [7:0]   model_store [FRAME_DEPTH];
    int           model_count = 0;
    int           model_len = 0;
    logic [7:0]   model_crc = 8'd0;
    int           model_ticks = 0;
    logic         model_link = 1'b0;
    logic [15:0]  model_timeout = TIMEOUT_RESET;

    rc_result_t fresh_results [$];
    rc_result_t awaited_results [$];

    int errors = 0;
    int sent_count = 0;
    int burst_left = 0;
    int stall_cycles = 0;
    int tick_pct = 0;
    int tick_burst = 1;
    bit steady_send = 1'b0;
    bit hold_off_req = 1'b0;

    crsf_rc_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_link_valid    (m_link_valid),
        .m_last          (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // CRC-8, polynomial 0xD5, MSB first, no reflection.
    function automatic logic [7:0] crc8_dvb(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Raw 11-bit stick value to pulse width, truncating, then clamped.
    function automatic logic [CHAN_W-1:0] scale_channel(input int raw);
        int v;
        if (raw <= int'(RAW_MIN)) begin
            v = int'(OUT_MIN);
        end else begin
            v = (raw - int'(RAW_MIN)) * (int'(OUT_MAX) - int'(OUT_MIN))
                / (int'(RAW_MAX) - int'(RAW_MIN)) + int'(OUT_MIN);
            if (v > int'(OUT_MAX)) begin
                v = int'(OUT_MAX);
            end
        end
        return CHAN_W'(v);
    endfunction

    // Advances the receiver state by one accepted request and leaves its results
    // in fresh_results.
    task automatic parse_and_decode(input in_mode_t md, input logic [7:0] b);
        int acc;
        int bits;
        int ch;
        rc_result_t r;
        fresh_results.delete();
        if (md == MODE_TICK) begin
            if (model_ticks < int'(TICK_MAX)) begin
                model_ticks++;
            end
            if (model_ticks > int'(model_timeout) && model_link) begin
                model_link = 1'b0;
                fresh_results.push_back(LINK_LOST_RESULT);
            end
        end else begin
            case (model_phase)
                PH_ADDR: begin
                    model_phase = PH_LEN;
                end
                PH_LEN: begin
                    model_len = int'(b);
                    model_count = 0;
                    model_crc = 8'd0;
                    model_phase = (b < MIN_LENGTH || b > MAX_LENGTH) ? PH_ADDR : PH_DATA;
                end
                default: begin
                    if (model_count >= FRAME_DEPTH || model_count >= model_len) begin
                        model_phase = PH_ADDR;
                    end else begin
                        model_store[model_count] = b;
                        model_count++;
                        if (model_count < model_len) begin
                            model_crc = crc8_dvb(model_crc, b);
                        end else begin
                            model_phase = PH_ADDR;
                            if (model_crc == b && model_store[0] == TYPE_RC_CHANNELS) begin
                                model_ticks = 0;
                                model_link = 1'b1;
                                acc = 0;
                                bits = 0;
                                ch = 0;
                                // Payload bytes are packed LSB first, 11 bits per channel.
                                for (int i = 1; i <= LAST_PAYLOAD_BYTE && ch < NUM_CHANNELS;
                                     i++) begin
                                    acc = acc | (int'(model_store[i]) << bits);
                                    bits += 8;
                                    while (bits >= CHAN_W && ch < NUM_CHANNELS) begin
                                        r.kind = KIND_CHANNEL;
                                        r.idx = CHAN_IDX_W'(ch);
                                        r.pulse = scale_channel(acc & ((1 << CHAN_W) - 1));
                                        r.link = 1'b1;
                                        r.is_last = (ch == NUM_CHANNELS - 1);
                                        fresh_results.push_back(r);
                                        acc = acc >> CHAN_W;
                                        bits -= CHAN_W;
                                        ch++;
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
        end
    endtask

    // Offers one request in the sender's burst pattern and records what it should cause.
    // Entered and left at a falling edge.
    task automatic send_request(input in_mode_t md, input logic [7:0] b,
                                input bit typed_lost = 1'b0);
        if (burst_left <= 0) begin
            if (!steady_send) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_and_decode(md, b);
        if (typed_lost) begin
            awaited_results.push_back(LINK_LOST_RESULT);
        end else begin
            foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
        end
        sent_count++;
        burst_left--;
        @(negedge aclk);
    endtask

    // A link byte, possibly preceded by a run of ticks.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tick_pct) begin
            repeat ($urandom_range(1, tick_burst)) send_request(MODE_TICK, 8'($urandom));
        end
        send_request(MODE_BYTE, b);
    endtask

    // Feeds filler bytes until the parser waits for an address again.
    task automatic resync_parser();
        while (model_phase != PH_ADDR) send_byte(8'($urandom));
    endtask

    task automatic send_frame(input int len, input logic [7:0] ftype, input bit corrupt);
        logic [7:0] body;
        logic [7:0] crc;
        resync_parser();
        send_byte(8'($urandom));
        send_byte(8'(len));
        crc = 8'd0;
        for (int i = 0; i < len - 1; i++) begin
            body = (i == 0) ? ftype : 8'($urandom);
            crc = crc8_dvb(crc, body);
            send_byte(body);
        end
        send_byte(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc);
    endtask

    function automatic int pick_length();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return int'(MIN_LENGTH);
        if (pick == 1) return int'(MAX_LENGTH);
        return $urandom_range(int'(MIN_LENGTH), int'(MAX_LENGTH));
    endfunction

    function automatic logic [7:0] other_type();
        logic [7:0] t;
        do t = 8'($urandom); while (t == TYPE_RC_CHANNELS);
        return t;
    endfunction

    // One random unit: mostly well-formed frames, some broken ones and line noise.
    task automatic random_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_frame(CHANNEL_FRAME_LEN, TYPE_RC_CHANNELS, 1'b0);
        end else if (pick < 65) begin
            send_frame(pick_length(), TYPE_RC_CHANNELS, 1'b0);
        end else if (pick < 73) begin
            send_frame(pick_length(), other_type(), 1'b0);
        end else if (pick < 81) begin
            send_frame(pick_length(), $urandom_range(0, 1) ? TYPE_RC_CHANNELS : other_type(),
                       1'b1);
        end else if (pick < 88) begin
            resync_parser();
            send_byte(8'($urandom));
            case ($urandom_range(0, 2))
                0: send_byte(8'd0);
                1: send_byte(MIN_LENGTH - 8'd1);
                default: send_byte(8'($urandom_range(int'(MAX_LENGTH) + 1, 255)));
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
    endtask

    task automatic run_mix(input int budget);
        int stop_at;
        stop_at = sent_count + budget;
        while (sent_count < stop_at) random_unit();
    endtask

    // Stops offering, waits for every awaited result, then lets the block settle.
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (awaited_results.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        model_timeout = value;
    endtask

    // Result side: a rotating stall pattern, replaced now and then, and one long hold-off.
    initial begin : ready_pattern
        logic [15:0] pat;
        int age;
        pat = 16'hFFFF;
        age = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (age == 0) begin
                    case ($urandom_range(0, 3))
                        0: pat = 16'hFFFF;
                        1: pat = 16'($urandom);
                        2: pat = 16'($urandom) & 16'($urandom);
                        default: pat = 16'($urandom) | 16'($urandom);
                    endcase
                    age = $urandom_range(16, 96);
                end
                age--;
                m_ready <= pat[0];
                pat = {pat[0], pat[15:1]};
            end
        end
    end

    // Compare each accepted result with the oldest awaited one.
    always @(posedge aclk) begin : check_results
        rc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d index %0d value %0d",
                       m_kind, m_channel_index, m_channel_value);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    errors++;
                end
                if (m_channel_index !== want.idx) begin
                    $error("channel_index: expected %0d, got %0d", want.idx, m_channel_index);
                    errors++;
                end
                if (m_channel_value !== want.pulse) begin
                    $error("channel_value: expected %0d, got %0d", want.pulse, m_channel_value);
                    errors++;
                end
                if (m_link_valid !== want.link) begin
                    $error("link_valid: expected %0d, got %0d", want.link, m_link_valid);
                    errors++;
                end
                if (m_last !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, m_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        foreach (model_store[i]) model_store[i] = 8'd0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset timeout: a short channel frame over a cleared store, then a few ticks
        // that stay well inside the default timeout.
        send_frame(int'(MIN_LENGTH), TYPE_RC_CHANNELS, 1'b0);
        repeat (OPENING_TICKS) send_request(MODE_TICK, 8'($urandom));
        drain_results(SETTLE_CYCLES);

        // Directed rows.
        set_timeout(16'd2);
        foreach (DIRECTED_ROWS[i]) begin
            send_request(DIRECTED_ROWS[i].md, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].lost);
        end
        drain_results(SETTLE_CYCLES);

        // Zero timeout: any tick after a good frame drops the link.
        set_timeout(16'd0);
        tick_pct = 8;
        tick_burst = 3;
        run_mix(60);
        drain_results(SETTLE_CYCLES);

        // Short timeout with long tick runs; the result side holds off while a channel
        // frame decodes, and the sender pauses for the results halfway.
        set_timeout(16'($urandom_range(1, 30)));
        tick_pct = 3;
        tick_burst = 40;
        hold_off_req = 1'b1;
        send_frame(CHANNEL_FRAME_LEN, TYPE_RC_CHANNELS, 1'b0);
        run_mix(30);
        drain_results(0);
        run_mix(40);
        drain_results(SETTLE_CYCLES);

        set_timeout(16'($urandom_range(31, 120)));
        tick_pct = 4;
        tick_burst = 60;
        run_mix(60);
        drain_results(SETTLE_CYCLES);

        // Largest timeout: a run of ticks after a good frame leaves the link up.
        set_timeout(TICK_MAX);
        tick_pct = 0;
        send_frame(CHANNEL_FRAME_LEN, TYPE_RC_CHANNELS, 1'b0);
        steady_send = 1'b1;
        repeat (MAX_TIMEOUT_TICKS) send_request(MODE_TICK, 8'($urandom));
        steady_send = 1'b0;
        drain_results(SETTLE_CYCLES);

        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/crsf_pkg.sv
rtl/crsf_frame_store.sv
rtl/crsf_chan_map.sv
rtl/crsf_rc_frame_receiver.sv
rtl/crsf_checker.sv
sim/tb.sv
